[hw/rtl/hcrm_pkg.sv]
// Package for the hall current RMS meter.
// Operation and result codes, controller states, datapath commands and status.
// No dependencies.
package hcrm_pkg;

  typedef enum logic [1:0] {
    OP_DC    = 2'd0,
    OP_AC    = 2'd1,
    OP_CAL   = 2'd2,
    OP_SPARE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_DC   = 2'd0,
    KIND_AC   = 2'd1,
    KIND_ZERO = 2'd2
  } kind_e;

  localparam logic CFG_ZERO_POINT  = 1'b0;
  localparam logic CFG_SENSOR_TYPE = 1'b1;

  localparam logic [9:0]  ZERO_RESET    = 10'd512;
  localparam logic [63:0] VCC_NUMERATOR = 64'd1125300;
  localparam logic [16:0] MA_LIMIT      = 17'd100000;
  localparam logic [9:0]  MA_PER_V      = 10'd1000;
  localparam int          DIV_STEPS     = 64;
  localparam int          SQRT_STEPS    = 28;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_MEAN_GO,
    S_MEAN_RUN,
    S_SQRT_GO,
    S_SQRT_RUN,
    S_VCC_GO,
    S_VCC_RUN,
    S_MUL1,
    S_MUL2,
    S_SCALE_GO,
    S_SCALE_RUN,
    S_CAL_GO,
    S_FINISH
  } state_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_ACCUM,
    CMD_DIV_MEAN,
    CMD_DIV_VCC,
    CMD_DIV_SCALE,
    CMD_DIV_CAL,
    CMD_DIV_STEP,
    CMD_SQRT_START,
    CMD_SQRT_STEP,
    CMD_MUL1,
    CMD_MUL2,
    CMD_FINISH
  } cmd_e;

  typedef struct packed {
    op_e  op;
    logic last;
    logic cal_full;
    logic div_last;
    logic sqrt_last;
    logic out_free;
  } status_t;

endpackage

[hw/rtl/hcrm_ctrl.sv]
// Controller of the hall current RMS meter: sequences one item at a time.
// Depends on hcrm_pkg.
module hcrm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  hcrm_pkg::status_t status_i,
  output hcrm_pkg::cmd_e    cmd_o
);

  hcrm_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hcrm_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = hcrm_pkg::CMD_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      hcrm_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o   = hcrm_pkg::CMD_LOAD;
          state_d = hcrm_pkg::S_DISPATCH;
        end
      end
      hcrm_pkg::S_DISPATCH: begin
        unique case (status_i.op)
          hcrm_pkg::OP_DC: begin
            cmd_o   = hcrm_pkg::CMD_DIV_VCC;
            state_d = hcrm_pkg::S_VCC_RUN;
          end
          hcrm_pkg::OP_AC: begin
            cmd_o   = hcrm_pkg::CMD_ACCUM;
            state_d = status_i.last ? hcrm_pkg::S_MEAN_GO : hcrm_pkg::S_IDLE;
          end
          hcrm_pkg::OP_CAL: begin
            cmd_o   = hcrm_pkg::CMD_ACCUM;
            state_d = status_i.cal_full ? hcrm_pkg::S_CAL_GO : hcrm_pkg::S_IDLE;
          end
          default: state_d = hcrm_pkg::S_IDLE;
        endcase
      end
      hcrm_pkg::S_MEAN_GO: begin
        cmd_o   = hcrm_pkg::CMD_DIV_MEAN;
        state_d = hcrm_pkg::S_MEAN_RUN;
      end
      hcrm_pkg::S_MEAN_RUN: begin
        cmd_o = hcrm_pkg::CMD_DIV_STEP;
        if (status_i.div_last) state_d = hcrm_pkg::S_SQRT_GO;
      end
      hcrm_pkg::S_SQRT_GO: begin
        cmd_o   = hcrm_pkg::CMD_SQRT_START;
        state_d = hcrm_pkg::S_SQRT_RUN;
      end
      hcrm_pkg::S_SQRT_RUN: begin
        cmd_o = hcrm_pkg::CMD_SQRT_STEP;
        if (status_i.sqrt_last) state_d = hcrm_pkg::S_VCC_GO;
      end
      hcrm_pkg::S_VCC_GO: begin
        cmd_o   = hcrm_pkg::CMD_DIV_VCC;
        state_d = hcrm_pkg::S_VCC_RUN;
      end
      hcrm_pkg::S_VCC_RUN: begin
        cmd_o = hcrm_pkg::CMD_DIV_STEP;
        if (status_i.div_last) state_d = hcrm_pkg::S_MUL1;
      end
      hcrm_pkg::S_MUL1: begin
        cmd_o   = hcrm_pkg::CMD_MUL1;
        state_d = hcrm_pkg::S_MUL2;
      end
      hcrm_pkg::S_MUL2: begin
        cmd_o   = hcrm_pkg::CMD_MUL2;
        state_d = hcrm_pkg::S_SCALE_GO;
      end
      hcrm_pkg::S_SCALE_GO: begin
        cmd_o   = hcrm_pkg::CMD_DIV_SCALE;
        state_d = hcrm_pkg::S_SCALE_RUN;
      end
      hcrm_pkg::S_SCALE_RUN: begin
        cmd_o = hcrm_pkg::CMD_DIV_STEP;
        if (status_i.div_last) state_d = hcrm_pkg::S_FINISH;
      end
      hcrm_pkg::S_CAL_GO: begin
        cmd_o   = hcrm_pkg::CMD_DIV_CAL;
        state_d = hcrm_pkg::S_FINISH;
      end
      hcrm_pkg::S_FINISH: begin
        if (status_i.out_free) begin
          cmd_o   = hcrm_pkg::CMD_FINISH;
          state_d = hcrm_pkg::S_IDLE;
        end
      end
      default: state_d = hcrm_pkg::S_IDLE;
    endcase
  end

endmodule

[hw/rtl/hcrm_datapath.sv]
// Datapath of the hall current RMS meter: accumulators, shared restoring
// divider, digit-by-digit square root, scaling multipliers, result register.
// Depends on hcrm_pkg.
module hcrm_datapath #(
  parameter int ADC_FULL_SCALE = 1023,
  parameter int CAL_SAMPLES    = 10,
  parameter int COUNT_BITS     = 20
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hcrm_pkg::cmd_e    cmd_i,
  output hcrm_pkg::status_t status_o,
  input  logic [1:0]        in_op_i,
  input  logic [9:0]        in_sample_i,
  input  logic [9:0]        in_ref_i,
  input  logic              in_last_i,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [9:0]        cfg_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        out_kind_o,
  output logic [17:0]       out_ma_o,
  output logic [9:0]        out_zero_o,
  output logic [19:0]       out_window_o
);

  localparam logic [31:0] DEN_185   = 32'(ADC_FULL_SCALE * 185);
  localparam logic [31:0] DEN_100   = 32'(ADC_FULL_SCALE * 100);
  localparam logic [31:0] DEN_66    = 32'(ADC_FULL_SCALE * 66);
  localparam int          EXT_W     = COUNT_BITS + 20;
  // calibration mean by reciprocal multiply, exact for a 14-bit sum
  localparam logic [18:0] CAL_RECIP = 19'(((1 << 18) + CAL_SAMPLES - 1) / CAL_SAMPLES);

  hcrm_pkg::op_e op_q;
  logic [9:0]  s_q, ref_q, zero_q;
  logic        last_q;
  logic [1:0]  sens_q;
  logic [39:0] sum_q;
  logic [COUNT_BITS-1:0] cnt_q;
  logic [13:0] csum_q;
  logic [3:0]  ccnt_q;
  logic [27:0] mag_q;
  logic        neg_q;
  logic [30:0] vk_q;
  logic [58:0] prod_q;
  logic [63:0] dvd_q;
  logic [31:0] dvs_q, rem_q;
  logic [5:0]  dcnt_q;
  logic [55:0] v_q, res_q, bit_q;
  logic [4:0]  scnt_q;
  logic        out_valid_q;
  logic [1:0]  out_kind_q;
  logic [17:0] out_ma_q;
  logic [9:0]  out_zero_q;
  logic [19:0] out_window_q;

  logic [9:0]  diff;
  logic        s_above;
  logic [19:0] sq;
  logic [40:0] sum_ext;
  logic [32:0] rem_sh;
  logic        qbit;
  logic [55:0] trial;
  logic [31:0] den;
  logic [16:0] ma;
  logic [EXT_W-1:0] cnt_ext;
  logic [32:0] cal_prod;

  assign s_above  = s_q > zero_q;
  assign diff     = s_above ? s_q - zero_q : zero_q - s_q;
  assign sq       = 20'(diff) * 20'(diff);
  assign sum_ext  = {1'b0, sum_q} + 41'(sq);
  assign rem_sh   = {rem_q, dvd_q[63]};
  assign qbit     = rem_sh >= {1'b0, dvs_q};
  assign trial    = res_q + bit_q;
  assign ma       = (dvd_q > 64'(hcrm_pkg::MA_LIMIT)) ? hcrm_pkg::MA_LIMIT : dvd_q[16:0];
  assign cnt_ext  = EXT_W'(cnt_q);
  assign cal_prod = 33'(csum_q) * 33'(CAL_RECIP);

  always_comb begin
    unique case (sens_q)
      2'd0:    den = DEN_185;
      2'd1:    den = DEN_100;
      default: den = DEN_66;
    endcase
    if (op_q == hcrm_pkg::OP_AC) den = {den[23:0], 8'd0};
  end

  assign status_o.op        = op_q;
  assign status_o.last      = last_q;
  assign status_o.cal_full  = (5'(ccnt_q) + 5'd1) >= 5'(CAL_SAMPLES);
  assign status_o.div_last  = dcnt_q == 6'(hcrm_pkg::DIV_STEPS - 1);
  assign status_o.sqrt_last = scnt_q == 5'(hcrm_pkg::SQRT_STEPS - 1);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_q      <= hcrm_pkg::ZERO_RESET;
      sens_q      <= 2'd0;
      sum_q       <= '0;
      cnt_q       <= '0;
      csum_q      <= '0;
      ccnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i == hcrm_pkg::CMD_FINISH) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_index_i == hcrm_pkg::CFG_ZERO_POINT) zero_q <= cfg_data_i;
        else sens_q <= cfg_data_i[1:0];
      end
      unique case (cmd_i)
        hcrm_pkg::CMD_ACCUM: begin
          if (op_q == hcrm_pkg::OP_AC) begin
            if (cnt_q != '1) begin
              sum_q <= sum_ext[40] ? '1 : sum_ext[39:0];
              cnt_q <= cnt_q + 1'b1;
            end
          end else begin
            csum_q <= csum_q + 14'(s_q);
            ccnt_q <= ccnt_q + 4'd1;
          end
        end
        hcrm_pkg::CMD_FINISH: begin
          if (op_q == hcrm_pkg::OP_AC) begin
            sum_q <= '0;
            cnt_q <= '0;
          end else if (op_q == hcrm_pkg::OP_CAL) begin
            zero_q <= dvd_q[9:0];
            csum_q <= '0;
            ccnt_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      hcrm_pkg::CMD_LOAD: begin
        op_q   <= hcrm_pkg::op_e'(in_op_i);
        s_q    <= in_sample_i;
        ref_q  <= in_ref_i;
        last_q <= in_last_i;
      end
      hcrm_pkg::CMD_DIV_MEAN: begin
        dvd_q  <= 64'(sum_q);
        dvs_q  <= 32'(cnt_q);
        rem_q  <= '0;
        dcnt_q <= '0;
      end
      hcrm_pkg::CMD_DIV_VCC: begin
        if (op_q == hcrm_pkg::OP_DC) begin
          mag_q <= 28'(diff);
          neg_q <= s_above;
        end else begin
          mag_q <= res_q[27:0];
          neg_q <= 1'b0;
        end
        dvd_q  <= hcrm_pkg::VCC_NUMERATOR;
        dvs_q  <= (ref_q == 10'd0) ? 32'd1 : 32'(ref_q);
        rem_q  <= '0;
        dcnt_q <= '0;
      end
      hcrm_pkg::CMD_DIV_SCALE: begin
        dvd_q  <= 64'(prod_q);
        dvs_q  <= den;
        rem_q  <= '0;
        dcnt_q <= '0;
      end
      hcrm_pkg::CMD_DIV_CAL: dvd_q <= 64'(cal_prod[32:18]);
      hcrm_pkg::CMD_DIV_STEP: begin
        rem_q  <= qbit ? 32'(rem_sh - {1'b0, dvs_q}) : rem_sh[31:0];
        dvd_q  <= {dvd_q[62:0], qbit};
        dcnt_q <= dcnt_q + 6'd1;
      end
      hcrm_pkg::CMD_SQRT_START: begin
        v_q    <= {dvd_q[39:0], 16'd0};
        res_q  <= '0;
        bit_q  <= 56'd1 << 54;
        scnt_q <= '0;
      end
      hcrm_pkg::CMD_SQRT_STEP: begin
        if (v_q >= trial) begin
          v_q   <= v_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q  <= bit_q >> 2;
        scnt_q <= scnt_q + 5'd1;
      end
      hcrm_pkg::CMD_MUL1: vk_q <= 31'(dvd_q[20:0]) * 31'(hcrm_pkg::MA_PER_V);
      hcrm_pkg::CMD_MUL2: prod_q <= 59'(mag_q) * 59'(vk_q);
      hcrm_pkg::CMD_FINISH: begin
        out_zero_q <= (op_q == hcrm_pkg::OP_CAL) ? dvd_q[9:0] : zero_q;
        unique case (op_q)
          hcrm_pkg::OP_DC: begin
            out_kind_q   <= hcrm_pkg::KIND_DC;
            out_ma_q     <= (neg_q && ma != '0) ? 18'(-18'(ma)) : 18'(ma);
            out_window_q <= '0;
          end
          hcrm_pkg::OP_AC: begin
            out_kind_q   <= hcrm_pkg::KIND_AC;
            out_ma_q     <= 18'(ma);
            out_window_q <= (cnt_ext > EXT_W'(20'hFFFFF)) ? 20'hFFFFF : cnt_ext[19:0];
          end
          default: begin
            out_kind_q   <= hcrm_pkg::KIND_ZERO;
            out_ma_q     <= '0;
            out_window_q <= '0;
          end
        endcase
      end
      default: ;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign out_kind_o   = out_kind_q;
  assign out_ma_o     = out_ma_q;
  assign out_zero_o   = out_zero_q;
  assign out_window_o = out_window_q;

endmodule

[hw/rtl/hall_current_rms_meter.sv]
// One beat is in flight at a time: a new beat is accepted only while the controller
// is idle, after the current beat has been processed.
// DC reads and AC window ends run through the shared 64-step restoring divider, and AC window
// ends also through the 28-step root; a finish also waits for the output register to drain.
// A finished result waits in an output register while the next beat is taken.
// Reset (async, active low): zero point 512, sensor 185 mV/A, sums and counts 0.
module hall_current_rms_meter #(
  parameter int ADC_FULL_SCALE = 1023,
  parameter int CAL_SAMPLES    = 10,
  parameter int COUNT_BITS     = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // sample[9:0], reference_reading[19:10], zeros
  input  logic [1:0]  s_axis_tuser,  // operation[1:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // current_ma[17:0], zero_value[27:18], window_samples[47:28]
  output logic [1:0]  m_axis_tuser,  // result_kind[1:0]
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [9:0]  cfg_data_i
);

  hcrm_pkg::cmd_e    cmd;
  hcrm_pkg::status_t status;
  logic [17:0] ma;
  logic [9:0]  zero;
  logic [19:0] window;

  hcrm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  hcrm_datapath #(
    .ADC_FULL_SCALE (ADC_FULL_SCALE),
    .CAL_SAMPLES    (CAL_SAMPLES),
    .COUNT_BITS     (COUNT_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .in_op_i      (s_axis_tuser),
    .in_sample_i  (s_axis_tdata[9:0]),
    .in_ref_i     (s_axis_tdata[19:10]),
    .in_last_i    (s_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_kind_o   (m_axis_tuser),
    .out_ma_o     (ma),
    .out_zero_o   (zero),
    .out_window_o (window)
  );

  assign m_axis_tdata = {window, zero, ma};

endmodule
